>>> hdl/stl_pkg.sv
// shared types, codes and character helpers for the script token lexer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package stl_pkg;

	localparam int LINE_BITS   = 16;
	localparam int MAX_RESULTS = 5;
	localparam int COUNT_BITS  = $clog2(MAX_RESULTS + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	// result kinds
	localparam logic [1:0] RK_CHAR  = 2'd0;
	localparam logic [1:0] RK_END   = 2'd1;
	localparam logic [1:0] RK_ERROR = 2'd2;
	localparam logic [1:0] RK_EOI   = 2'd3;

	// token kinds
	localparam logic [2:0] TK_NUMBER  = 3'd0;
	localparam logic [2:0] TK_STRING  = 3'd1;
	localparam logic [2:0] TK_IDENT   = 3'd2;
	localparam logic [2:0] TK_KEYWORD = 3'd3;
	localparam logic [2:0] TK_OPER    = 3'd4;

	// keyword prefix codes
	localparam logic [3:0] KW_NONE = 4'd0;
	localparam logic [3:0] KW_I    = 4'd1;
	localparam logic [3:0] KW_IF   = 4'd2;
	localparam logic [3:0] KW_E    = 4'd3;
	localparam logic [3:0] KW_EL   = 4'd4;
	localparam logic [3:0] KW_ELS  = 4'd5;
	localparam logic [3:0] KW_ELSE = 4'd6;
	localparam logic [3:0] KW_D    = 4'd7;
	localparam logic [3:0] KW_DE   = 4'd8;
	localparam logic [3:0] KW_DEF  = 4'd9;

	// characters
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_LD     = 8'h64;
	localparam logic [7:0] CH_LE     = 8'h65;
	localparam logic [7:0] CH_LF     = 8'h66;
	localparam logic [7:0] CH_LI     = 8'h69;
	localparam logic [7:0] CH_LL     = 8'h6C;
	localparam logic [7:0] CH_LS     = 8'h73;

	typedef enum logic [2:0] {
		M_IDLE,
		M_NUMBER,
		M_IDENT,
		M_STRING,
		M_OPER,
		M_COMMENT
	} mode_t;

	typedef struct packed {
		logic [7:0] source_char;
		logic       end_of_source;
	} src_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [2:0]  token_kind;
		logic [7:0]  token_char;
		logic [15:0] line_number;
		logic        last_of_run;
	} res_item_t;

	// all results caused by one source byte
	typedef struct packed {
		res_item_t [MAX_RESULTS-1:0] item;
		logic [COUNT_BITS-1:0]       count;
	} run_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
			(c == CH_USCORE);
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) ||
			(c == CH_CR);
	endfunction

	function automatic logic starts_pair(input logic [7:0] c);
		return (c == CH_EQ) || (c == CH_PLUS) || (c == CH_BANG) || (c == CH_MINUS) ||
			(c == CH_SLASH) || (c == CH_STAR);
	endfunction

	function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
		return ((b == CH_EQ) && ((a == CH_EQ) || (a == CH_PLUS) || (a == CH_BANG) ||
			(a == CH_MINUS))) || ((a == CH_SLASH) && (b == CH_SLASH)) ||
			((a == CH_STAR) && (b == CH_STAR));
	endfunction

	function automatic logic [3:0] kw_start(input logic [7:0] c);
		logic [3:0] p;
		p = KW_NONE;
		if (c == CH_LI) p = KW_I;
		else if (c == CH_LE) p = KW_E;
		else if (c == CH_LD) p = KW_D;
		return p;
	endfunction

	function automatic logic [3:0] kw_next(input logic [3:0] p, input logic [7:0] c);
		logic [3:0] n;
		n = KW_NONE;
		if ((p == KW_I) && (c == CH_LF)) n = KW_IF;
		else if ((p == KW_E) && (c == CH_LL)) n = KW_EL;
		else if ((p == KW_EL) && (c == CH_LS)) n = KW_ELS;
		else if ((p == KW_ELS) && (c == CH_LE)) n = KW_ELSE;
		else if ((p == KW_D) && (c == CH_LE)) n = KW_DE;
		else if ((p == KW_DE) && (c == CH_LF)) n = KW_DEF;
		return n;
	endfunction

	function automatic logic kw_done(input logic [3:0] p);
		return (p == KW_IF) || (p == KW_ELSE) || (p == KW_DEF);
	endfunction

	// saturating line count
	function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] l);
		return (l == {LINE_BITS{1'b1}}) ? l : l + 1'b1;
	endfunction

	// line as shown on a result, held at the field's maximum
	function automatic logic [15:0] line_show(input logic [LINE_BITS-1:0] l);
		logic [32:0] w;
		w = 33'(l);
		return (w > 33'd65535) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic run_t run_push(input run_t r, input logic [1:0] rk,
		input logic [2:0] tk, input logic [7:0] ch, input logic [LINE_BITS-1:0] l);
		run_t o;
		o = r;
		if (r.count < COUNT_BITS'(MAX_RESULTS)) begin
			o.item[r.count].result_kind = rk;
			o.item[r.count].token_kind  = tk;
			o.item[r.count].token_char  = ch;
			o.item[r.count].line_number = line_show(l);
			o.item[r.count].last_of_run = 1'b0;
			o.count = r.count + 1'b1;
		end
		return o;
	endfunction

endpackage

>>> hdl/stl_front.sv
// front end: accepts source bytes, runs the scan state and builds the result run per byte
// depends on stl_pkg
`timescale 1ns / 1ps

module stl_front import stl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  src_item_t source,
	output logic      push,
	output run_t      run
);

	mode_t                mode_q, mode_d;
	logic                 quote_q, quote_d;
	logic [7:0]           held_q, held_d;
	logic [LINE_BITS-1:0] line_q, line_d;
	logic [3:0]           kw_q, kw_d;
	logic                 nonempty_q, nonempty_d;
	run_t                 run_d;

	// next state and the results this byte causes
	always_comb begin
		logic [7:0] c;
		logic       do_idle;
		c          = source.source_char;
		do_idle    = 1'b0;
		mode_d     = mode_q;
		quote_d    = quote_q;
		held_d     = held_q;
		line_d     = line_q;
		kw_d       = kw_q;
		nonempty_d = nonempty_q;
		run_d      = '0;

		case (mode_q)
			M_NUMBER: begin
				if (is_digit(c) || (c == CH_DOT)) begin
					run_d = run_push(run_d, RK_CHAR, TK_NUMBER, c, line_d);
				end else begin
					run_d   = run_push(run_d, RK_END, TK_NUMBER, 8'h00, line_d);
					mode_d  = M_IDLE;
					do_idle = 1'b1;
				end
			end
			M_IDENT: begin
				if (is_word(c)) begin
					kw_d  = kw_next(kw_q, c);
					run_d = run_push(run_d, RK_CHAR, TK_IDENT, c, line_d);
				end else begin
					run_d   = run_push(run_d, RK_END, kw_done(kw_q) ? TK_KEYWORD : TK_IDENT,
						8'h00, line_d);
					mode_d  = M_IDLE;
					kw_d    = KW_NONE;
					do_idle = 1'b1;
				end
			end
			M_STRING: begin
				if (c == (quote_q ? CH_DQUOTE : CH_SQUOTE)) begin
					// empty strings give no token end
					if (nonempty_q) begin
						run_d = run_push(run_d, RK_END, TK_STRING, 8'h00, line_d);
					end
					mode_d     = M_IDLE;
					nonempty_d = 1'b0;
					quote_d    = 1'b0;
				end else begin
					run_d      = run_push(run_d, RK_CHAR, TK_STRING, c, line_d);
					nonempty_d = 1'b1;
					if (c == CH_NL) line_d = line_inc(line_d);
				end
			end
			M_COMMENT: begin
				if (c == CH_NL) begin
					line_d = line_inc(line_d);
					mode_d = M_IDLE;
				end
			end
			M_OPER: begin
				run_d  = run_push(run_d, RK_CHAR, TK_OPER, held_q, line_d);
				mode_d = M_IDLE;
				held_d = 8'h00;
				if (is_pair(held_q, c)) begin
					run_d = run_push(run_d, RK_CHAR, TK_OPER, c, line_d);
					run_d = run_push(run_d, RK_END, TK_OPER, 8'h00, line_d);
				end else begin
					run_d   = run_push(run_d, RK_END, TK_OPER, 8'h00, line_d);
					do_idle = 1'b1;
				end
			end
			default: begin
				mode_d  = M_IDLE;
				do_idle = 1'b1;
			end
		endcase

		// byte seen between tokens
		if (do_idle && !is_blank(c)) begin
			if (c == CH_HASH) begin
				mode_d = M_COMMENT;
			end else if (is_digit(c)) begin
				mode_d = M_NUMBER;
				run_d  = run_push(run_d, RK_CHAR, TK_NUMBER, c, line_d);
			end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
				mode_d     = M_STRING;
				quote_d    = (c == CH_DQUOTE);
				nonempty_d = 1'b0;
			end else if (is_word(c)) begin
				mode_d = M_IDENT;
				kw_d   = kw_start(c);
				run_d  = run_push(run_d, RK_CHAR, TK_IDENT, c, line_d);
			end else if (starts_pair(c)) begin
				mode_d = M_OPER;
				held_d = c;
			end else begin
				run_d = run_push(run_d, RK_CHAR, TK_OPER, c, line_d);
				run_d = run_push(run_d, RK_END, TK_OPER, 8'h00, line_d);
				if (c == CH_NL) line_d = line_inc(line_d);
			end
		end

		// final byte flushes the pending token and returns to reset state
		if (source.end_of_source) begin
			case (mode_d)
				M_NUMBER: run_d = run_push(run_d, RK_END, TK_NUMBER, 8'h00, line_d);
				M_IDENT:  run_d = run_push(run_d, RK_END,
					kw_done(kw_d) ? TK_KEYWORD : TK_IDENT, 8'h00, line_d);
				M_STRING: run_d = run_push(run_d, RK_ERROR, TK_STRING, 8'h00, line_d);
				M_OPER: begin
					run_d = run_push(run_d, RK_CHAR, TK_OPER, held_d, line_d);
					run_d = run_push(run_d, RK_END, TK_OPER, 8'h00, line_d);
				end
				default: ;
			endcase
			run_d      = run_push(run_d, RK_EOI, TK_NUMBER, 8'h00, line_d);
			mode_d     = M_IDLE;
			quote_d    = 1'b0;
			held_d     = 8'h00;
			line_d     = LINE_BITS'(1);
			kw_d       = KW_NONE;
			nonempty_d = 1'b0;
		end
	end

	// queue request and last-of-run marking
	always_comb begin
		run  = run_d;
		push = accept && (run_d.count != '0);
		if (run_d.count != '0) begin
			run.item[run_d.count - 1'b1].last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_IDLE;
			quote_q    <= 1'b0;
			held_q     <= 8'h00;
			line_q     <= LINE_BITS'(1);
			kw_q       <= KW_NONE;
			nonempty_q <= 1'b0;
		end else if (accept) begin
			mode_q     <= mode_d;
			quote_q    <= quote_d;
			held_q     <= held_d;
			line_q     <= line_d;
			kw_q       <= kw_d;
			nonempty_q <= nonempty_d;
		end
	end

endmodule

>>> hdl/stl_queue.sv
// short queue of result runs between the front and back ends
// depends on stl_pkg
`timescale 1ns / 1ps

module stl_queue import stl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  run_t push_run,
	input  logic pop,
	output run_t head,
	output logic empty,
	output logic full
);

	run_t                 slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_q;
	logic [QPTR_BITS-1:0] rd_q;
	logic [QPTR_BITS:0]   fill_q;

	assign empty = (fill_q == '0);
	assign full  = (fill_q == (QPTR_BITS + 1)'(QUEUE_DEPTH));
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

>>> hdl/stl_back.sv
// back end: unpacks result runs from the queue and delivers one result per cycle while result_stall is low
// depends on stl_pkg
`timescale 1ns / 1ps

module stl_back import stl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  run_t      head,
	input  logic      empty,
	output logic      pop,
	output logic      result_valid,
	input  logic      result_stall,
	output res_item_t result
);

	run_t                  cur_q;
	logic                  cur_valid_q;
	logic [COUNT_BITS-1:0] idx_q;
	res_item_t             out_q;
	logic                  out_valid_q;
	logic                  load;
	logic                  take;
	logic                  cur_done;

	assign load     = !out_valid_q || !result_stall;
	assign take     = load && cur_valid_q;
	assign cur_done = take && (idx_q == cur_q.count - 1'b1);
	assign pop      = !empty && (!cur_valid_q || cur_done);

	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
		if (take) out_q <= cur_q.item[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) out_valid_q <= cur_valid_q;
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (cur_done) begin
				cur_valid_q <= 1'b0;
			end else if (take) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

>>> hdl/script_token_lexer.sv
// script token lexer top level: front end, run queue and back end
// depends on stl_pkg, stl_front, stl_queue, stl_back
`timescale 1ns / 1ps

// Streaming tokenizer. The source channel carries one byte per request with an
// end_of_source flag on the final byte; the result channel carries token
// characters, token ends (with final token kind and line), string errors and an
// end of input marker, with last_of_run set on the final result of each byte.
// A byte is taken every cycle while the four-entry run queue has room; a byte
// that causes no result still takes its cycle. While result_stall is low the back
// end delivers one result per cycle, so sustained throughput is one byte per cycle
// when bytes average at most one result, and otherwise paced by the result count
// (at most five per byte). The first result of a byte passes through the run
// queue, the back end's current-run register and the output register.
// A stalled result holds its value; the output register and the run queue let
// new bytes enter while results wait, until the queue fills and source_stall
// rises. Reset clears the scan state to idle between tokens on line one and
// empties the queue and output register; there is no clearing pass.
module script_token_lexer import stl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      source_valid,
	output logic      source_stall,
	input  src_item_t source,
	output logic      result_valid,
	input  logic      result_stall,
	output res_item_t result
);

	logic accept;
	logic push;
	run_t push_run;
	logic pop;
	run_t head;
	logic empty;
	logic full;

	assign source_stall = full;
	assign accept       = source_valid && !full;

	stl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.source (source),
		.push   (push),
		.run    (push_run)
	);

	stl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_run (push_run),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	stl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

>>> hdl/stl_checker.sv
// port-level checks for the script token lexer, bound to the top level
// depends on stl_pkg and script_token_lexer
`timescale 1ns / 1ps

module stl_checker import stl_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      result_valid,
	input logic      result_stall,
	input res_item_t result
);

	// a stalled result stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result changed while stalled");

	// end of input always closes the run of its byte
	a_eoi_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.result_kind == RK_EOI) |-> result.last_of_run)
		else $error("end of input not last of run");

	a_error_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.result_kind == RK_ERROR) |->
		(result.token_kind == TK_STRING) && result.last_of_run == 1'b0)
		else $error("string error with wrong kind or position");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.line_number != 16'd0))
		else $error("line number zero");

endmodule

bind script_token_lexer stl_checker u_checker (.*);

>>> verif/script_token_lexer_tb.sv
// testbench for script_token_lexer: directed table and random scripts
// depends on stl_pkg and the script_token_lexer RTL; self-checking against a built-in predictor
`timescale 1ns / 1ps

module script_token_lexer_tb;
	import stl_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 20;
	localparam int BYTES_PER_PHASE = 75;
	// end of input carries no token kind
	localparam logic [2:0] TK_NONE = 3'd0;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      source_valid = 1'b0;
	logic      source_stall;
	src_item_t source = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	res_item_t result;

	script_token_lexer u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.source_valid(source_valid),
		.source_stall(source_stall),
		.source      (source),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always #5 clk = ~clk;

	// predictor state
	mode_t                lex_mode = M_IDLE;
	logic                 in_dquote = 1'b0;
	logic [7:0]           held_op = '0;
	logic [LINE_BITS-1:0] cur_line = LINE_BITS'(1);
	logic [3:0]           kw_prog = KW_NONE;
	logic                 str_has_chars = 1'b0;

	res_item_t  byte_run[$];
	res_item_t  token_results_due[$];
	res_item_t  dir_typed[$];
	src_item_t  dir_in[$];
	int         dir_known[$];
	logic [7:0] script_q[$];

	int src_idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	int    idle_mix[4] = '{0, 76, 0, 34};
	int    stall_mix[4] = '{0, 0, 76, 34};
	string kw_words[11] = '{"if", "else", "def", "i", "el", "els", "de", "iff", "elsex",
		"define", "deff"};
	string op_words[20] = '{"==", "+=", "!=", "-=", "//", "**", "=", "+", "!", "-", "/",
		"*", "<", "(", ")", ":", "%", "=!", "*/", "+-"};

	function automatic logic is_num(input logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) || c == CH_USCORE;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
	endfunction

	function automatic logic opens_pair(input logic [7:0] c);
		return c == CH_EQ || c == CH_PLUS || c == CH_BANG || c == CH_MINUS ||
			c == CH_SLASH || c == CH_STAR;
	endfunction

	function automatic logic closes_pair(input logic [7:0] a, input logic [7:0] b);
		if (b == CH_EQ)
			return a == CH_EQ || a == CH_PLUS || a == CH_BANG || a == CH_MINUS;
		return (a == CH_SLASH && b == CH_SLASH) || (a == CH_STAR && b == CH_STAR);
	endfunction

	// keyword prefix tracking: first letter opens a prefix, later letters extend it
	function automatic logic [3:0] kw_step(input logic first, input logic [3:0] p,
		input logic [7:0] c);
		if (first) begin
			case (c)
				CH_LI: return KW_I;
				CH_LE: return KW_E;
				CH_LD: return KW_D;
				default: return KW_NONE;
			endcase
		end
		case (p)
			KW_I: if (c == CH_LF) return KW_IF;
			KW_E: if (c == CH_LL) return KW_EL;
			KW_EL: if (c == CH_LS) return KW_ELS;
			KW_ELS: if (c == CH_LE) return KW_ELSE;
			KW_D: if (c == CH_LE) return KW_DE;
			KW_DE: if (c == CH_LF) return KW_DEF;
			default: ;
		endcase
		return KW_NONE;
	endfunction

	function automatic void note(input logic [1:0] rk, input logic [2:0] tk,
		input logic [7:0] ch);
		logic [15:0] shown;
		shown = (32'(cur_line) > 32'd65535) ? 16'hFFFF : 16'(cur_line);
		if (byte_run.size() < MAX_RESULTS)
			byte_run.push_back({rk, tk, ch, shown, 1'b0});
	endfunction

	function automatic void bump_line();
		if (cur_line != {LINE_BITS{1'b1}})
			cur_line = cur_line + 1'b1;
	endfunction

	function automatic void end_ident();
		if (kw_prog == KW_IF || kw_prog == KW_ELSE || kw_prog == KW_DEF)
			note(RK_END, TK_KEYWORD, 8'h00);
		else
			note(RK_END, TK_IDENT, 8'h00);
	endfunction

	function automatic void lex_clear();
		lex_mode = M_IDLE;
		in_dquote = 1'b0;
		held_op = '0;
		cur_line = LINE_BITS'(1);
		kw_prog = KW_NONE;
		str_has_chars = 1'b0;
	endfunction

	function automatic void lex_idle(input logic [7:0] c);
		if (is_space(c))
			return;
		if (c == CH_HASH) begin
			lex_mode = M_COMMENT;
		end else if (is_num(c)) begin
			lex_mode = M_NUMBER;
			note(RK_CHAR, TK_NUMBER, c);
		end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
			lex_mode = M_STRING;
			in_dquote = c == CH_DQUOTE;
			str_has_chars = 1'b0;
		end else if (is_letter(c)) begin
			lex_mode = M_IDENT;
			kw_prog = kw_step(1'b1, KW_NONE, c);
			note(RK_CHAR, TK_IDENT, c);
		end else if (opens_pair(c)) begin
			lex_mode = M_OPER;
			held_op = c;
		end else begin
			// single-character operator, a bare newline included
			note(RK_CHAR, TK_OPER, c);
			note(RK_END, TK_OPER, 8'h00);
			if (c == CH_NL)
				bump_line();
		end
	endfunction

	function automatic void lex_byte(input logic [7:0] c);
		case (lex_mode)
			M_NUMBER: begin
				if (is_num(c) || c == CH_DOT) begin
					note(RK_CHAR, TK_NUMBER, c);
					return;
				end
				note(RK_END, TK_NUMBER, 8'h00);
				lex_mode = M_IDLE;
			end
			M_IDENT: begin
				if (is_letter(c)) begin
					kw_prog = kw_step(1'b0, kw_prog, c);
					note(RK_CHAR, TK_IDENT, c);
					return;
				end
				end_ident();
				lex_mode = M_IDLE;
				kw_prog = KW_NONE;
			end
			M_STRING: begin
				if (c == (in_dquote ? CH_DQUOTE : CH_SQUOTE)) begin
					// empty strings vanish
					if (str_has_chars)
						note(RK_END, TK_STRING, 8'h00);
					lex_mode = M_IDLE;
					str_has_chars = 1'b0;
					in_dquote = 1'b0;
					return;
				end
				note(RK_CHAR, TK_STRING, c);
				str_has_chars = 1'b1;
				if (c == CH_NL)
					bump_line();
				return;
			end
			M_COMMENT: begin
				if (c == CH_NL) begin
					bump_line();
					lex_mode = M_IDLE;
				end
				return;
			end
			M_OPER: begin
				note(RK_CHAR, TK_OPER, held_op);
				lex_mode = M_IDLE;
				if (closes_pair(held_op, c)) begin
					note(RK_CHAR, TK_OPER, c);
					note(RK_END, TK_OPER, 8'h00);
					held_op = '0;
					return;
				end
				note(RK_END, TK_OPER, 8'h00);
				held_op = '0;
			end
			default: lex_mode = M_IDLE;
		endcase
		lex_idle(c);
	endfunction

	function automatic void lex_predict(input src_item_t item);
		res_item_t r;
		byte_run.delete();
		lex_byte(item.source_char);
		if (item.end_of_source) begin
			case (lex_mode)
				M_NUMBER: note(RK_END, TK_NUMBER, 8'h00);
				M_IDENT: end_ident();
				M_STRING: note(RK_ERROR, TK_STRING, 8'h00);
				M_OPER: begin
					note(RK_CHAR, TK_OPER, held_op);
					note(RK_END, TK_OPER, 8'h00);
				end
				default: ;
			endcase
			note(RK_EOI, TK_NONE, 8'h00);
			lex_clear();
		end
		if (byte_run.size() > 0) begin
			r = byte_run.pop_back();
			r.last_of_run = 1'b1;
			byte_run.push_back(r);
		end
	endfunction

	function automatic void table_row(input logic [7:0] ch, input logic eos, input int known);
		dir_in.push_back({ch, eos});
		dir_known.push_back(known);
	endfunction

	function automatic void table_expect(input logic [1:0] rk, input logic [2:0] tk,
		input logic [7:0] ch, input logic [15:0] line, input logic last);
		dir_typed.push_back({rk, tk, ch, line, last});
	endfunction

	function automatic logic [7:0] word_char();
		case ($urandom_range(2))
			0: return CH_LA + 8'($urandom_range(25));
			1: return CH_UA + 8'($urandom_range(25));
			default: return CH_USCORE;
		endcase
	endfunction

	// one piece of script text: mostly well-formed tokens, some noise
	function automatic void add_snippet();
		string      w;
		int         n;
		logic [7:0] qc;
		case ($urandom_range(11))
			0, 1: begin
				script_q.push_back(CH_0 + 8'($urandom_range(9)));
				n = $urandom_range(4);
				repeat (n)
					script_q.push_back(($urandom_range(3) == 0) ? CH_DOT :
						CH_0 + 8'($urandom_range(9)));
			end
			2: begin
				n = $urandom_range(1, 6);
				repeat (n) script_q.push_back(word_char());
			end
			3: begin
				w = kw_words[$urandom_range(10)];
				for (int i = 0; i < w.len(); i++) script_q.push_back(w[i]);
			end
			4, 5: begin
				qc = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
				script_q.push_back(qc);
				n = $urandom_range(5);
				repeat (n) begin
					case ($urandom_range(5))
						0: script_q.push_back(CH_NL);
						1: script_q.push_back((qc == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE);
						2: script_q.push_back(8'($urandom_range(255)));
						default: script_q.push_back(8'($urandom_range(32, 126)));
					endcase
				end
				if ($urandom_range(7) != 0)
					script_q.push_back(qc);
			end
			6, 7: begin
				w = op_words[$urandom_range(19)];
				for (int i = 0; i < w.len(); i++) script_q.push_back(w[i]);
			end
			8: begin
				script_q.push_back(CH_HASH);
				n = $urandom_range(5);
				repeat (n) begin
					qc = 8'($urandom_range(255));
					script_q.push_back((qc == CH_NL) ? CH_SPACE : qc);
				end
				if ($urandom_range(5) != 0)
					script_q.push_back(CH_NL);
			end
			9: begin
				case ($urandom_range(4))
					0: script_q.push_back(CH_TAB);
					1: script_q.push_back(CH_VT);
					2: script_q.push_back(CH_FF);
					3: script_q.push_back(CH_CR);
					default: script_q.push_back(CH_SPACE);
				endcase
			end
			10: script_q.push_back(CH_NL);
			default: script_q.push_back(8'($urandom_range(255)));
		endcase
	endfunction

	function automatic void check_result(input res_item_t got);
		res_item_t want;
		if (token_results_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected result kind %0d tok %0d char %02h line %0d last %0b",
					$time, got.result_kind, got.token_kind, got.token_char, got.line_number,
					got.last_of_run);
			return;
		end
		want = token_results_due.pop_front();
		if (got.result_kind !== want.result_kind || got.token_kind !== want.token_kind ||
			got.token_char !== want.token_char || got.line_number !== want.line_number ||
			got.last_of_run !== want.last_of_run) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: mismatch exp kind %0d tok %0d char %02h line %0d last %0b, %s%0d %s%0d %s%02h %s%0d %s%0b",
					$time, want.result_kind, want.token_kind, want.token_char,
					want.line_number, want.last_of_run,
					"got kind ", got.result_kind, "tok ", got.token_kind,
					"char ", got.token_char, "line ", got.line_number,
					"last ", got.last_of_run);
		end
	endfunction

	// result side: check, random stall, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				check_result(result);
			if ((result_valid && !result_stall) || (source_valid && !source_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			result_stall <= ($urandom_range(99) < stall_pct);
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no request accepted for %0d cycles", QUIET_LIMIT);
				$display("script_token_lexer verification failed");
				$finish;
			end
		end
	end

	task automatic send_byte(input src_item_t item, input int known);
		while ($urandom_range(99) < src_idle_pct) begin
			source_valid <= 1'b0;
			source <= src_item_t'($urandom_range(511));
			@(posedge clk);
		end
		source_valid <= 1'b1;
		source <= item;
		@(posedge clk);
		while (source_stall) @(posedge clk);
		lex_predict(item);
		if (known == 0) begin
			foreach (byte_run[k]) token_results_due.push_back(byte_run[k]);
		end else begin
			repeat (known) token_results_due.push_back(dir_typed.pop_front());
		end
	endtask

	// sender holds off until every predicted result has been taken
	task automatic await_drain();
		source_valid <= 1'b0;
		@(posedge clk);
		while (token_results_due.size() != 0) @(posedge clk);
	endtask

	initial begin
		int sent;
		int target;

		// directed table: typed rows carry their own results, the rest use the predictor
		table_row(8'h00, 1'b0, 2);
		table_expect(RK_CHAR, TK_OPER, 8'h00, 16'd1, 1'b0);
		table_expect(RK_END, TK_OPER, 8'h00, 16'd1, 1'b1);
		table_row(8'hFF, 1'b0, 2);
		table_expect(RK_CHAR, TK_OPER, 8'hFF, 16'd1, 1'b0);
		table_expect(RK_END, TK_OPER, 8'h00, 16'd1, 1'b1);
		table_row(CH_NL, 1'b0, 2);
		table_expect(RK_CHAR, TK_OPER, CH_NL, 16'd1, 1'b0);
		table_expect(RK_END, TK_OPER, 8'h00, 16'd1, 1'b1);
		table_row("9", 1'b0, 0);
		table_row(CH_DOT, 1'b0, 0);
		table_row("i", 1'b0, 0);
		table_row("f", 1'b0, 0);
		table_row(CH_SPACE, 1'b0, 0);
		table_row("e", 1'b0, 0);
		table_row("l", 1'b0, 0);
		table_row("s", 1'b0, 0);
		table_row("e", 1'b0, 0);
		table_row("7", 1'b0, 0);
		table_row(CH_PLUS, 1'b0, 0);
		table_row(CH_EQ, 1'b0, 0);
		table_row(CH_STAR, 1'b0, 0);
		table_row("x", 1'b0, 0);
		table_row(CH_DQUOTE, 1'b0, 0);
		table_row(CH_SQUOTE, 1'b0, 0);
		table_row(CH_DQUOTE, 1'b0, 0);
		table_row(CH_SQUOTE, 1'b0, 0);
		table_row(CH_SQUOTE, 1'b0, 0);
		table_row(CH_HASH, 1'b0, 0);
		table_row("z", 1'b0, 0);
		table_row(CH_NL, 1'b0, 0);
		table_row(CH_DQUOTE, 1'b0, 0);
		// open string at end of source
		table_row("a", 1'b1, 3);
		table_expect(RK_CHAR, TK_STRING, "a", 16'd3, 1'b0);
		table_expect(RK_ERROR, TK_STRING, 8'h00, 16'd3, 1'b0);
		table_expect(RK_EOI, TK_NONE, 8'h00, 16'd3, 1'b1);
		// held operator flushed at end of source
		table_row(CH_MINUS, 1'b1, 3);
		table_expect(RK_CHAR, TK_OPER, CH_MINUS, 16'd1, 1'b0);
		table_expect(RK_END, TK_OPER, 8'h00, 16'd1, 1'b0);
		table_expect(RK_EOI, TK_NONE, 8'h00, 16'd1, 1'b1);

		lex_clear();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_in[i]) send_byte(dir_in[i], dir_known[i]);

		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct = idle_mix[ph];
			stall_pct = stall_mix[ph];
			sent = 0;
			while (sent < BYTES_PER_PHASE) begin
				script_q.delete();
				target = $urandom_range(8, 40);
				while (script_q.size() < target) add_snippet();
				foreach (script_q[i])
					send_byte({script_q[i], i == script_q.size() - 1}, 0);
				sent += script_q.size();
			end
			await_drain();
		end

		await_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && token_results_due.size() == 0)
			$display("script_token_lexer verification clean");
		else
			$display("script_token_lexer verification failed");
		$finish;
	end

endmodule
